// ===== design/she_pkg.sv =====
// ----------------------------------------------------------------------------
// she_pkg: shared types and helpers for the spring edge Hessian triplets block
// Record types between the units, square root and divider digit steps,
// and the axis-pair ordering of the emitted 3x3 blocks.
// ----------------------------------------------------------------------------
package she_pkg;

	localparam int VTX_W  = 17;
	localparam int IDX_W  = 18;
	localparam int POS_W  = 32;
	localparam int VAL_W  = 32;
	localparam int MAG_W  = 30;
	localparam int ROOT_W = 31;
	localparam int SUM_W  = 62;
	localparam int DVS_W  = 34;

	localparam logic [VTX_W-1:0] POINT_COUNT_RST = VTX_W'(65536);

	// position of the last triplet of an edge
	localparam logic [1:0] LAST_BLK = 2'd3;
	localparam logic [3:0] LAST_POS = 4'd8;

	// edge after length extraction
	typedef struct packed {
		logic [VTX_W-1:0]           vi;
		logic [VTX_W-1:0]           vj;
		logic [POS_W-1:0]           rest;
		logic [2:0][MAG_W-1:0]      mag;
		logic [2:0]                 neg;
		logic [1:0]                 shift;
		logic [ROOT_W-1:0]          norm;
	} root_rec_t;

	// edge with its six distinct Hessian entries: xx, yy, zz, xy, xz, yz
	typedef struct packed {
		logic [VTX_W-1:0]           vi;
		logic [VTX_W-1:0]           vj;
		logic [5:0][VAL_W-1:0]      kval;
		logic                       degen;
	} k_rec_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} sqrt_st_t;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] quo;
	} div_st_t;

	// one digit of the bitwise integer square root
	function automatic sqrt_st_t sqrt_step(sqrt_st_t st, logic [1:0] pair);
		logic [35:0] r2;
		logic [35:0] trial;
		sqrt_st_t    nx;
		r2    = {st.rem, pair};
		trial = {2'b00, st.root, 2'b01};
		if (r2 >= trial) begin
			nx.rem  = 34'(r2 - trial);
			nx.root = {st.root[30:0], 1'b1};
		end else begin
			nx.rem  = r2[33:0];
			nx.root = {st.root[30:0], 1'b0};
		end
		return nx;
	endfunction

	// one quotient bit of restoring division, remainder kept below twice the divisor
	function automatic div_st_t div_step(div_st_t st, logic [DVS_W-1:0] dvs);
		logic        ge;
		logic [34:0] r;
		div_st_t     nx;
		ge     = st.rem >= {1'b0, dvs};
		r      = ge ? st.rem - {1'b0, dvs} : st.rem;
		nx.quo = {st.quo[30:0], ge};
		nx.rem = {r[33:0], 1'b0};
		return nx;
	endfunction

	// emitted order within a block: xx yy zz yx zx zy xy xz yz
	function automatic logic [1:0] row_axis(logic [3:0] p);
		logic [1:0] a;
		case (p)
			4'd1, 4'd3, 4'd8: a = 2'd1;
			4'd2, 4'd4, 4'd5: a = 2'd2;
			default:          a = 2'd0;
		endcase
		return a;
	endfunction

	function automatic logic [1:0] col_axis(logic [3:0] p);
		logic [1:0] a;
		case (p)
			4'd1, 4'd5, 4'd6: a = 2'd1;
			4'd2, 4'd7, 4'd8: a = 2'd2;
			default:          a = 2'd0;
		endcase
		return a;
	endfunction

	// stored entry order: xx yy zz xy xz yz
	function automatic logic [1:0] slot_row(logic [2:0] s);
		logic [1:0] a;
		case (s)
			3'd1, 3'd5: a = 2'd1;
			3'd2:       a = 2'd2;
			default:    a = 2'd0;
		endcase
		return a;
	endfunction

	function automatic logic [1:0] slot_col(logic [2:0] s);
		logic [1:0] a;
		case (s)
			3'd1, 3'd3: a = 2'd1;
			3'd2, 3'd4, 3'd5: a = 2'd2;
			default:    a = 2'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== design/she_front.sv =====
// ----------------------------------------------------------------------------
// she_front: edge intake and length
// Forms the coordinate differences, scales them below 2^30, sums the squares
// on one multiplier and takes the integer square root two digits a cycle.
// ----------------------------------------------------------------------------
module she_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [she_pkg::VTX_W-1:0]    vertex_i,
	input  logic [she_pkg::VTX_W-1:0]    vertex_j,
	input  logic signed [she_pkg::POS_W-1:0] pos_i_x,
	input  logic signed [she_pkg::POS_W-1:0] pos_i_y,
	input  logic signed [she_pkg::POS_W-1:0] pos_i_z,
	input  logic signed [she_pkg::POS_W-1:0] pos_j_x,
	input  logic signed [she_pkg::POS_W-1:0] pos_j_y,
	input  logic signed [she_pkg::POS_W-1:0] pos_j_z,
	input  logic [she_pkg::POS_W-1:0]    rest_length,
	output logic                         rr_valid,
	input  logic                         rr_ready,
	output she_pkg::root_rec_t           rr
);

	typedef enum logic [1:0] {F_IDLE, F_SQ, F_ROOT, F_OUT} fstate_t;

	fstate_t                state_q;
	logic [3:0]             cnt_q;
	logic [she_pkg::SUM_W-1:0] acc_q;
	logic [63:0]            rad_q;
	she_pkg::sqrt_st_t      st_q;
	logic [she_pkg::VTX_W-1:0] vi_q, vj_q;
	logic [she_pkg::POS_W-1:0] rest_q;
	logic [2:0][she_pkg::MAG_W-1:0] mag_q;
	logic [2:0]             neg_q;
	logic [1:0]             shift_q;

	logic [2:0][32:0]       dif;
	logic [2:0][32:0]       mag_full;
	logic [2:0]             neg_in;
	logic [1:0]             shift_in;
	logic [2:0][she_pkg::MAG_W-1:0] mag_in;
	logic                   take;
	logic [she_pkg::MAG_W-1:0] sq_op;
	logic [59:0]            sq;
	she_pkg::sqrt_st_t      st_mid, st_nx;

	always_comb begin
		dif[0] = {pos_i_x[31], pos_i_x} - {pos_j_x[31], pos_j_x};
		dif[1] = {pos_i_y[31], pos_i_y} - {pos_j_y[31], pos_j_y};
		dif[2] = {pos_i_z[31], pos_i_z} - {pos_j_z[31], pos_j_z};
		for (int a = 0; a < 3; a++) begin
			neg_in[a]   = dif[a][32];
			mag_full[a] = neg_in[a] ? 33'(-dif[a]) : dif[a];
		end
		if ((mag_full[0] | mag_full[1] | mag_full[2]) < 33'h0_4000_0000)
			shift_in = 2'd0;
		else if ((mag_full[0] | mag_full[1] | mag_full[2]) < 33'h0_8000_0000)
			shift_in = 2'd1;
		else if ((mag_full[0] | mag_full[1] | mag_full[2]) < 33'h1_0000_0000)
			shift_in = 2'd2;
		else
			shift_in = 2'd3;
		for (int a = 0; a < 3; a++)
			mag_in[a] = she_pkg::MAG_W'(mag_full[a] >> shift_in);
	end

	assign in_ready = (state_q == F_IDLE) || (state_q == F_OUT && rr_ready);
	assign take     = in_valid && in_ready;

	assign sq_op  = mag_q[cnt_q[1:0]];
	assign sq     = sq_op * sq_op;
	assign st_mid = she_pkg::sqrt_step(st_q, rad_q[63:62]);
	assign st_nx  = she_pkg::sqrt_step(st_mid, rad_q[61:60]);

	assign rr_valid   = (state_q == F_OUT);
	assign rr.vi      = vi_q;
	assign rr.vj      = vj_q;
	assign rr.rest    = rest_q;
	assign rr.mag     = mag_q;
	assign rr.neg     = neg_q;
	assign rr.shift   = shift_q;
	assign rr.norm    = st_q.root[she_pkg::ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE, F_OUT: begin
					if (take) begin
						state_q <= F_SQ;
						cnt_q   <= '0;
					end else if (state_q == F_OUT && rr_ready) begin
						state_q <= F_IDLE;
					end
				end
				F_SQ: begin
					if (cnt_q == 4'd2) begin
						state_q <= F_ROOT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				F_ROOT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15)
						state_q <= F_OUT;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			vi_q    <= vertex_i;
			vj_q    <= vertex_j;
			rest_q  <= rest_length;
			mag_q   <= mag_in;
			neg_q   <= neg_in;
			shift_q <= shift_in;
			acc_q   <= '0;
		end
		if (state_q == F_SQ) begin
			acc_q <= acc_q + she_pkg::SUM_W'(sq);
			if (cnt_q == 4'd2) begin
				rad_q <= {2'b00, acc_q + she_pkg::SUM_W'(sq)};
				st_q  <= '0;
			end
		end
		if (state_q == F_ROOT) begin
			st_q  <= st_nx;
			rad_q <= {rad_q[59:0], 4'b0000};
		end
	end

endmodule

// ===== design/she_calc.sv =====
// ----------------------------------------------------------------------------
// she_calc: Hessian entries of one edge
// Four restoring dividers (lambda and the unit vector) two bits a cycle, then
// a two-multiplier chain forms the six distinct entries of K.
// ----------------------------------------------------------------------------
module she_calc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rr_valid,
	output logic               rr_ready,
	input  she_pkg::root_rec_t rr,
	output logic               kr_valid,
	input  logic               kr_ready,
	output she_pkg::k_rec_t    kr
);

	typedef enum logic [1:0] {C_IDLE, C_DIV, C_MUL, C_OUT} cstate_t;

	cstate_t              state_q;
	logic [3:0]           cnt_q;
	logic [2:0]           mcnt_q;
	she_pkg::root_rec_t   rec_q;
	logic [she_pkg::DVS_W-1:0] nfull_q;
	she_pkg::div_st_t     dv_q [4];
	logic [29:0]          e_q;
	logic [2:0]           eslot_q;
	logic [5:0][she_pkg::VAL_W-1:0] kval_q;

	logic                 take;
	logic [she_pkg::DVS_W-1:0] nfull_in;
	logic [she_pkg::DVS_W-1:0] lam_num;
	logic [she_pkg::DVS_W-1:0] norm_ext;
	she_pkg::div_st_t     dv_mid [4];
	she_pkg::div_st_t     dv_nx [4];
	logic [29:0]          lam;
	logic [29:0]          w;
	logic [2:0][30:0]     umag;
	logic [1:0]           ea, eb, ta, tb;
	logic [61:0]          p1;
	logic [61:0]          p1r;
	logic [59:0]          p2;
	logic [59:0]          p2r;
	logic [31:0]          t;
	logic [31:0]          kform;

	assign rr_ready = (state_q == C_IDLE) || (state_q == C_OUT && kr_ready);
	assign take     = rr_valid && rr_ready;

	assign nfull_in = she_pkg::DVS_W'(rr.norm) << rr.shift;
	assign lam_num  = ({2'b00, rr.rest} < nfull_in) ? nfull_in - {2'b00, rr.rest} : '0;
	assign norm_ext = she_pkg::DVS_W'(rec_q.norm);

	always_comb begin
		dv_mid[0] = she_pkg::div_step(dv_q[0], nfull_q);
		dv_nx[0]  = she_pkg::div_step(dv_mid[0], nfull_q);
		for (int a = 1; a < 4; a++) begin
			dv_mid[a] = she_pkg::div_step(dv_q[a], norm_ext);
			dv_nx[a]  = she_pkg::div_step(dv_mid[a], norm_ext);
		end
	end

	// quotients carry 2^31 scaling; drop bits down to Q1.29 and Q1.30
	assign lam = dv_q[0].quo[31:2];
	assign w   = 30'h2000_0000 - lam;
	always_comb begin
		for (int a = 0; a < 3; a++)
			umag[a] = dv_q[a+1].quo[31:1];
	end

	assign ea  = she_pkg::slot_row(mcnt_q);
	assign eb  = she_pkg::slot_col(mcnt_q);
	assign p1  = umag[ea] * umag[eb];
	assign p1r = p1 + 62'h8000_0000;

	assign ta  = she_pkg::slot_row(eslot_q);
	assign tb  = she_pkg::slot_col(eslot_q);
	assign p2  = w * e_q;
	assign p2r = p2 + 60'h800_0000;
	assign t   = p2r[59:28];

	always_comb begin
		if (eslot_q < 3'd3)
			kform = 32'(lam) + t;
		else if (rec_q.neg[ta] != rec_q.neg[tb])
			kform = -t;
		else
			kform = t;
	end

	assign kr_valid = (state_q == C_OUT);
	assign kr.vi    = rec_q.vi;
	assign kr.vj    = rec_q.vj;
	assign kr.kval  = kval_q;
	assign kr.degen = (rec_q.norm == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
			mcnt_q  <= '0;
		end else begin
			unique case (state_q)
				C_IDLE, C_OUT: begin
					if (take) begin
						state_q <= C_DIV;
						cnt_q   <= '0;
					end else if (state_q == C_OUT && kr_ready) begin
						state_q <= C_IDLE;
					end
				end
				C_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= C_MUL;
						mcnt_q  <= '0;
					end
				end
				C_MUL: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd6)
						state_q <= C_OUT;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rec_q      <= rr;
			nfull_q    <= nfull_in;
			dv_q[0]    <= '{rem: {1'b0, lam_num}, quo: '0};
			for (int a = 0; a < 3; a++)
				dv_q[a+1] <= '{rem: 35'(rr.mag[a]), quo: '0};
		end else if (state_q == C_DIV) begin
			for (int a = 0; a < 4; a++)
				dv_q[a] <= dv_nx[a];
		end
		if (state_q == C_MUL) begin
			if (mcnt_q < 3'd6) begin
				e_q     <= p1r[61:32];
				eslot_q <= mcnt_q;
			end
			if (mcnt_q != 3'd0)
				kval_q[eslot_q] <= kform;
		end
	end

endmodule

// ===== design/she_queue.sv =====
// ----------------------------------------------------------------------------
// she_queue: two-entry queue of finished edge records
// Parts the entry calculation from the triplet emitter.
// ----------------------------------------------------------------------------
module she_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  she_pkg::k_rec_t wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output she_pkg::k_rec_t rd_data
);

	she_pkg::k_rec_t mem_q [2];
	logic            wptr_q, rptr_q;
	logic [1:0]      count_q;
	logic            push, pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (pop)
				rptr_q <= ~rptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wr_data;
	end

endmodule

// ===== design/she_back.sv =====
// ----------------------------------------------------------------------------
// she_back: triplet emitter; holds the point_count register
// Walks the four blocks of nine entries of one edge record and presents one
// triplet a cycle through an output register unless out_ready stalls.
// ----------------------------------------------------------------------------
module she_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [she_pkg::VTX_W-1:0] cfg_wr_data,
	input  logic                      rec_valid,
	output logic                      rec_pop,
	input  she_pkg::k_rec_t           rec,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [she_pkg::IDX_W-1:0] row_index,
	output logic [she_pkg::IDX_W-1:0] col_index,
	output logic signed [she_pkg::VAL_W-1:0] entry_value,
	output logic                      degenerate,
	output logic                      last_entry
);

	logic [she_pkg::VTX_W-1:0] pc_q;
	logic [1:0]                blk_q;
	logic [3:0]                pos_q;

	logic                      load;
	logic                      at_last;
	logic [1:0]                ra, ca;
	logic [she_pkg::VTX_W-1:0] rv, cv;
	logic [she_pkg::IDX_W-1:0] pc_ext;
	logic [she_pkg::IDX_W-1:0] roff, coff;
	logic [2:0]                slot;
	logic [she_pkg::VAL_W-1:0] kv;
	logic [she_pkg::VAL_W-1:0] val;

	assign load    = rec_valid && (!out_valid || out_ready);
	assign at_last = (blk_q == she_pkg::LAST_BLK) && (pos_q == she_pkg::LAST_POS);
	assign rec_pop = load && at_last;

	assign ra     = she_pkg::row_axis(pos_q);
	assign ca     = she_pkg::col_axis(pos_q);
	assign rv     = (blk_q == 2'd0 || blk_q == 2'd2) ? rec.vi : rec.vj;
	assign cv     = (blk_q == 2'd0 || blk_q == 2'd3) ? rec.vi : rec.vj;
	assign pc_ext = she_pkg::IDX_W'(pc_q);

	always_comb begin
		case (ra)
			2'd1:    roff = pc_ext;
			2'd2:    roff = pc_ext << 1;
			default: roff = '0;
		endcase
		case (ca)
			2'd1:    coff = pc_ext;
			2'd2:    coff = pc_ext << 1;
			default: coff = '0;
		endcase
	end

	// mirrored pairs share the stored xy, xz, yz entries
	assign slot = (pos_q < 4'd6) ? pos_q[2:0] : 3'(pos_q - 4'd3);
	assign kv   = rec.kval[slot];
	assign val  = rec.degen ? '0 : (blk_q[1] ? -kv : kv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= she_pkg::POINT_COUNT_RST;
			blk_q     <= '0;
			pos_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_wr_en)
				pc_q <= cfg_wr_data;
			if (load) begin
				out_valid <= 1'b1;
				if (pos_q == she_pkg::LAST_POS) begin
					pos_q <= '0;
					blk_q <= blk_q + 2'd1;
				end else begin
					pos_q <= pos_q + 4'd1;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_index   <= she_pkg::IDX_W'(rv) + roff;
			col_index   <= she_pkg::IDX_W'(cv) + coff;
			entry_value <= val;
			degenerate  <= rec.degen;
			last_entry  <= at_last;
		end
	end

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> entry_value == '0)
		else $error("degenerate triplet carries a nonzero value");

	a_pop_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		rec_pop |=> blk_q == 2'd0 && pos_q == 4'd0)
		else $error("edge record released before its last triplet");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		load && at_last |=> out_valid && last_entry)
		else $error("last triplet not flagged");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= she_pkg::LAST_POS)
		else $error("block position out of range");

endmodule

// ===== design/spring_edge_hessian_triplets.sv =====
// ----------------------------------------------------------------------------
// spring_edge_hessian_triplets: projected mass-spring Hessian triplets
// One edge in, 36 (row, column, value) triplets out.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  in        in_valid / in_ready       vertex_i, vertex_j, pos_i_*, pos_j_*, rest_length
//  out       out_valid / out_ready     row_index, col_index, entry_value, degenerate,
//                                      last_entry
//  cfg       cfg_wr_en                 cfg_wr_data (point_count)
//
//  The emitter gives one triplet a cycle while the output is not stalled.
//  The first triplet passes the length unit (squares, then square root), the entry
//  unit (dividers, multiply chain, handoff), then the queue and output register.
//  Reset sets point_count to 65536 and empties every stage; no clearing pass.
//  A stalled output holds the emitter; the queue and the front units keep
//  accepting edges until their own stages fill.
// ----------------------------------------------------------------------------
module spring_edge_hessian_triplets (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [she_pkg::VTX_W-1:0]        cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [she_pkg::VTX_W-1:0]        vertex_i,
	input  logic [she_pkg::VTX_W-1:0]        vertex_j,
	input  logic signed [she_pkg::POS_W-1:0] pos_i_x,
	input  logic signed [she_pkg::POS_W-1:0] pos_i_y,
	input  logic signed [she_pkg::POS_W-1:0] pos_i_z,
	input  logic signed [she_pkg::POS_W-1:0] pos_j_x,
	input  logic signed [she_pkg::POS_W-1:0] pos_j_y,
	input  logic signed [she_pkg::POS_W-1:0] pos_j_z,
	input  logic [she_pkg::POS_W-1:0]        rest_length,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [she_pkg::IDX_W-1:0]        row_index,
	output logic [she_pkg::IDX_W-1:0]        col_index,
	output logic signed [she_pkg::VAL_W-1:0] entry_value,
	output logic                             degenerate,
	output logic                             last_entry
);

	logic               rr_valid, rr_ready;
	she_pkg::root_rec_t rr;
	logic               kr_valid, kr_ready;
	she_pkg::k_rec_t    kr;
	logic               q_valid, q_pop;
	she_pkg::k_rec_t    q_data;

	she_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.vertex_i    (vertex_i),
		.vertex_j    (vertex_j),
		.pos_i_x     (pos_i_x),
		.pos_i_y     (pos_i_y),
		.pos_i_z     (pos_i_z),
		.pos_j_x     (pos_j_x),
		.pos_j_y     (pos_j_y),
		.pos_j_z     (pos_j_z),
		.rest_length (rest_length),
		.rr_valid    (rr_valid),
		.rr_ready    (rr_ready),
		.rr          (rr)
	);

	she_calc u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.rr_valid (rr_valid),
		.rr_ready (rr_ready),
		.rr       (rr),
		.kr_valid (kr_valid),
		.kr_ready (kr_ready),
		.kr       (kr)
	);

	she_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (kr_valid),
		.wr_ready (kr_ready),
		.wr_data  (kr),
		.rd_valid (q_valid),
		.rd_ready (q_pop),
		.rd_data  (q_data)
	);

	she_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rec_valid   (q_valid),
		.rec_pop     (q_pop),
		.rec         (q_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.row_index   (row_index),
		.col_index   (col_index),
		.entry_value (entry_value),
		.degenerate  (degenerate),
		.last_entry  (last_entry)
	);

endmodule
